// ===== rtl/core/e2c_pkg.sv =====
// Shared types, constants and calendar helpers for the epoch-to-calendar block.
// Used by e2c_ctrl, e2c_datapath and the top level; depends on nothing.
package e2c_pkg;

  localparam int unsigned IN_W       = 32;
  localparam int unsigned OUT_W      = 40;
  localparam logic [7:0]  YEAR_LIMIT = 8'd255;
  localparam logic [3:0]  MONTHS     = 4'd12;
  localparam logic [5:0]  MINUTE_SECS   = 6'd60;
  localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
  localparam logic [5:0]  DAYS_PER_WEEK = 6'd7;
  localparam logic [31:0] EPOCH_WDAY_BIAS = 32'd4;  // 1970-01-01 was a Thursday

  // Reciprocals for constant division: q = (n * RECIP) >> SHIFT, exact for n < 2^32
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'h9249_2493;  // exact for n < 2^29
  localparam logic [5:0]  SHIFT_60 = 6'd37;
  localparam logic [5:0]  SHIFT_24 = 6'd36;
  localparam logic [5:0]  SHIFT_7  = 6'd34;

  // Which division the shared divider is running
  typedef enum logic [1:0] {
    PH_SEC  = 2'd0,
    PH_MIN  = 2'd1,
    PH_HOUR = 2'd2,
    PH_WDAY = 2'd3
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic   load;        // capture the request
    logic   div_step;    // multiply the dividend by the reciprocal
    logic   div_end;     // split the product into quotient and remainder
    phase_t phase;
    logic   year_step;   // subtract one year length
    logic   month_step;  // subtract one month length
    logic   push;        // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_full;
  } sts_t;

  function automatic logic [5:0] divisor_of(phase_t ph);
    logic [5:0] d;
    case (ph)
      PH_SEC:  d = MINUTE_SECS;
      PH_MIN:  d = MINS_PER_HOUR;
      PH_HOUR: d = HOURS_PER_DAY;
      PH_WDAY: d = DAYS_PER_WEEK;
      default: d = DAYS_PER_WEEK;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] recip_of(phase_t ph);
    logic [31:0] m;
    case (ph)
      PH_SEC:  m = RECIP_60;
      PH_MIN:  m = RECIP_60;
      PH_HOUR: m = RECIP_24;
      PH_WDAY: m = RECIP_7;
      default: m = RECIP_7;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] shift_of(phase_t ph);
    logic [5:0] s;
    case (ph)
      PH_SEC:  s = SHIFT_60;
      PH_MIN:  s = SHIFT_60;
      PH_HOUR: s = SHIFT_24;
      PH_WDAY: s = SHIFT_7;
      default: s = SHIFT_7;
    endcase
    return s;
  endfunction

  // Gregorian rule on 1970 + offset: offset 30 (2000) is leap,
  // offsets 130 (2100) and 230 (2200) are century years that are not.
  function automatic logic is_leap(logic [7:0] off);
    return (off[1:0] == 2'd2) && (off != 8'd130) && (off != 8'd230);
  endfunction

  function automatic logic [8:0] year_len(logic [7:0] off);
    return is_leap(off) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/epoch_to_calendar_unit.sv =====
// Epoch seconds to calendar date: top level joining e2c_ctrl and e2c_datapath.
// Steps: accept, four divisions (multiply, then split into quotient and remainder),
// the year loop, the month loop and the output push.
// One request at a time; the year loop sets the throughput, plus any wait for a full output.
// A finished result waits in the output register while the next request runs.
// Reset (rst_n low, synchronous) returns the controller to idle, drops out_tvalid.
module epoch_to_calendar_unit
  import e2c_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [31:0] epoch_seconds
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [5:0] second_of_minute, [11:6] minute_of_hour,
                                       // [16:12] hour_of_day, [19:17] weekday,
                                       // [27:20] year_offset, [31:28] month_number,
                                       // [36:32] day_of_month, [39:37] zero
);

  cmd_t cmd;
  sts_t sts;

  e2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  e2c_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/core/e2c_ctrl.sv =====
// Sequencing state machine for the epoch-to-calendar block.
// Depends on e2c_pkg; drives e2c_datapath through cmd_t and reads sts_t.
module e2c_ctrl
  import e2c_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_DEND  = 6'b000100,
    ST_YEAR  = 6'b001000,
    ST_MONTH = 6'b010000,
    ST_PUSH  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          phase_nxt = PH_SEC;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_DEND;
      end
      ST_DEND: begin
        cmd.div_end = 1'b1;
        if (phase_r == PH_WDAY) begin
          state_nxt = ST_YEAR;
        end else begin
          phase_nxt = phase_t'(phase_r + 2'd1);
          state_nxt = ST_DIV;
        end
      end
      ST_YEAR: begin
        if (sts.year_done) state_nxt = ST_MONTH;
        else cmd.year_step = 1'b1;
      end
      ST_MONTH: begin
        if (sts.month_done) state_nxt = ST_PUSH;
        else cmd.month_step = 1'b1;
      end
      ST_PUSH: begin
        if (!sts.out_full) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SEC;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/core/e2c_datapath.sv =====
// Datapath: shared reciprocal-multiply constant divider, year and month subtraction,
// and the output register. Depends on e2c_pkg; commanded by e2c_ctrl.
module e2c_datapath
  import e2c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IN_W-1:0]   in_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);

  logic [31:0]      num_r;
  logic [63:0]      prod_r;
  logic [5:0]       sec_r, min_r;
  logic [4:0]       hour_r;
  logic [2:0]       wday_r;
  logic [15:0]      days_r;
  logic [7:0]       year_r;
  logic [3:0]       month_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_valid_r, out_valid_nxt;

  // Quotient from the registered product, remainder by multiply-back
  logic [5:0]  divisor;
  logic [31:0] recip;
  logic [5:0]  shamt;
  logic [63:0] prod_sh;
  logic [31:0] quot;
  logic [31:0] rem_full;

  always_comb begin
    divisor  = divisor_of(cmd.phase);
    recip    = recip_of(cmd.phase);
    shamt    = shift_of(cmd.phase);
    prod_sh  = prod_r >> shamt;
    quot     = prod_sh[31:0];
    rem_full = num_r - quot * {26'd0, divisor};
  end

  // Year and month lengths for the current position
  logic [8:0] ylen;
  logic [4:0] mlen;

  always_comb begin
    ylen = year_len(year_r);
    mlen = month_len(month_r, is_leap(year_r));
    sts.year_done  = (year_r == YEAR_LIMIT) || (days_r < {7'd0, ylen});
    sts.month_done = (month_r == MONTHS) || (days_r < {11'd0, mlen});
    sts.out_full   = out_valid_r;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= in_data;
    end else if (cmd.div_step) begin
      prod_r <= {32'd0, num_r} * {32'd0, recip};
    end else if (cmd.div_end) begin
      case (cmd.phase)
        PH_SEC: begin
          sec_r <= rem_full[5:0];
          num_r <= quot;
        end
        PH_MIN: begin
          min_r <= rem_full[5:0];
          num_r <= quot;
        end
        PH_HOUR: begin
          hour_r <= rem_full[4:0];
          days_r <= quot[15:0];
          num_r  <= quot + EPOCH_WDAY_BIAS;
        end
        PH_WDAY: begin
          wday_r  <= rem_full[2:0] + 3'd1;
          year_r  <= '0;
          month_r <= '0;
        end
        default: num_r <= quot;
      endcase
    end else if (cmd.year_step) begin
      days_r <= days_r - {7'd0, ylen};
      year_r <= year_r + 8'd1;
    end else if (cmd.month_step) begin
      days_r  <= days_r - {11'd0, mlen};
      month_r <= month_r + 4'd1;
    end
  end

  // Output register; fields low to high: second, minute, hour, weekday,
  // year offset, month, day of month, zero fill
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= {3'd0, days_r[4:0] + 5'd1, month_r + 4'd1, year_r,
                     wday_r, hour_r, min_r, sec_r};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/e2c_checker.sv =====
// Port-level checks for epoch_to_calendar_unit, attached by bind.
// Depends only on the top level's ports.
module e2c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request in flight: no accept right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // Every result field lies in its calendar range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] < 6'd60) && (out_tdata[11:6] < 6'd60) &&
      (out_tdata[16:12] < 5'd24) && (out_tdata[19:17] != 3'd0) &&
      (out_tdata[27:20] <= 8'd136) && (out_tdata[31:28] != 4'd0) &&
      (out_tdata[31:28] <= 4'd12) && (out_tdata[36:32] != 5'd0) &&
      (out_tdata[39:37] == 3'd0))
    else $error("result field out of range");

  // Reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind epoch_to_calendar_unit e2c_checker u_e2c_checker (.*);

// ===== tb/tb_epoch_to_calendar_unit.sv =====
// Testbench for epoch_to_calendar_unit: epoch seconds in, calendar breakdown out.
// Directed table then random timestamps, checked against typed dates or a built-in calendar predictor.
// Depends on e2c_pkg (port widths) and the epoch_to_calendar_unit RTL.
`timescale 1ns / 100ps

module tb_epoch_to_calendar_unit;
  import e2c_pkg::*;

  localparam int unsigned DIR_ROWS    = 22;
  localparam int unsigned RAND_ITEMS  = 550;
  localparam int unsigned DRAIN_CYC   = 260;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SHOWN_MAX   = 10;
  localparam int unsigned DAY_SECS    = 86400;

  // One calendar result; packed so that it lines up with out_tdata[36:0]
  typedef struct packed {
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] sec;
  } cal_t;

  // Receiver behavior, switched at random during the run
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  cal_t        pending_dates[$];
  int unsigned mismatches;
  int unsigned cycle_count;

  logic [31:0] dir_secs  [DIR_ROWS];
  bit          dir_typed [DIR_ROWS];
  cal_t        dir_want  [DIR_ROWS];

  epoch_to_calendar_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Gregorian rule on 1970 + offset
  function automatic bit leap_at(int unsigned off);
    int unsigned y;
    y = 1970 + off;
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_year(int unsigned off);
    return leap_at(off) ? 366 : 365;
  endfunction

  // mo counts from 0 (January)
  function automatic int unsigned days_in_month(int unsigned mo, int unsigned off);
    int unsigned n;
    case (mo)
      1:             n = leap_at(off) ? 29 : 28;
      3, 5, 8, 10:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic cal_t cal(int unsigned s, int unsigned mi, int unsigned h,
                               int unsigned w, int unsigned y, int unsigned mo,
                               int unsigned d);
    cal_t c;
    c = '{sec: s[5:0], minute: mi[5:0], hour: h[4:0], wday: w[2:0],
          year: y[7:0], month: mo[3:0], mday: d[4:0]};
    return c;
  endfunction

  // Calendar breakdown of an epoch second count
  function automatic cal_t calendar_of(logic [31:0] secs);
    int unsigned t, days, yr, mo, s, mi, h, w;
    t    = secs;
    s    = t % 60;
    t    = t / 60;
    mi   = t % 60;
    t    = t / 60;
    h    = t % 24;
    days = t / 24;
    w    = (days + 4) % 7 + 1;  // day 0 was a Thursday
    yr   = 0;
    while (yr < 255 && days >= days_in_year(yr)) begin
      days -= days_in_year(yr);
      yr++;
    end
    mo = 0;
    while (mo < 12 && days >= days_in_month(mo, yr)) begin
      days -= days_in_month(mo, yr);
      mo++;
    end
    return cal(s, mi, h, w, yr, mo + 1, days + 1);
  endfunction

  // Seconds at midnight on the first of month mo of year 1970 + off (wraps past 2106)
  function automatic logic [31:0] month_start(int unsigned off, int unsigned mo);
    int unsigned days;
    days = 0;
    for (int unsigned y = 0; y < off; y++) days += days_in_year(y);
    for (int unsigned m = 0; m < mo; m++) days += days_in_month(m, off);
    return 32'(days * DAY_SECS);
  endfunction

  // Random timestamp, weighted toward year, month and leap-day edges
  function automatic logic [31:0] pick_secs();
    int unsigned roll, y;
    logic [31:0] s;
    roll = $urandom_range(0, 9);
    case (roll)
      3, 4: s = month_start($urandom_range(0, 136), 0)
                + $urandom_range(0, 2 * DAY_SECS) - DAY_SECS;
      5, 6: s = month_start($urandom_range(0, 136), $urandom_range(0, 11))
                + $urandom_range(0, 2 * DAY_SECS) - DAY_SECS;
      7: begin
        // end of February, with 2000 and 2100 picked often
        case ($urandom_range(0, 3))
          0:       y = 30;
          1:       y = 130;
          default: y = $urandom_range(0, 135);
        endcase
        s = month_start(y, 2) + $urandom_range(0, 3 * DAY_SECS) - 2 * DAY_SECS;
      end
      8:       s = $urandom_range(0, 5_000_000);
      9:       s = 32'hFFFF_FFFF - $urandom_range(0, 5_000_000);
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // Present one request at a falling edge and hold it until accepted
  task automatic send_req(input logic [31:0] secs, input bit typed, input cal_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dates.push_back(typed ? want : calendar_of(secs));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Directed rows: zero, the largest input, day and year edges, leap days, 2100
  initial begin
    dir_secs[0]  = 32'd0;          dir_typed[0] = 1'b1;
    dir_want[0]  = cal(0, 0, 0, 5, 0, 1, 1);
    dir_secs[1]  = 32'hFFFF_FFFF;  dir_typed[1] = 1'b1;
    dir_want[1]  = cal(15, 28, 6, 1, 136, 2, 7);
    dir_secs[2]  = 32'd59;         dir_typed[2] = 1'b1;
    dir_want[2]  = cal(59, 0, 0, 5, 0, 1, 1);
    dir_secs[3]  = 32'd86399;      dir_typed[3] = 1'b1;
    dir_want[3]  = cal(59, 59, 23, 5, 0, 1, 1);
    dir_secs[4]  = 32'd86400;      dir_typed[4] = 1'b1;
    dir_want[4]  = cal(0, 0, 0, 6, 0, 1, 2);
    dir_secs[5]  = 32'd3599;
    dir_secs[6]  = 32'd68169600;    // 1972-02-29
    dir_secs[7]  = 32'd94694399;    // last second of 1972
    dir_secs[8]  = 32'd94694400;
    dir_secs[9]  = 32'd946684799;   // last second of 1999
    dir_secs[10] = 32'd951782400;   // 2000-02-29, century leap year
    dir_secs[11] = 32'd951868800;   // 2000-03-01
    dir_secs[12] = 32'd978307199;   // last second of 2000
    dir_secs[13] = 32'h7FFF_FFFF;
    dir_secs[14] = 32'h8000_0000;
    dir_secs[15] = 32'hAAAA_AAAA;
    dir_secs[16] = 32'h5555_5555;
    dir_secs[17] = 32'd4102444799;  // last second of 2099
    dir_secs[18] = 32'd4102444800;  // 2100-01-01
    dir_secs[19] = 32'd4107542399;  // 2100-02-28, 2100 not leap
    dir_secs[20] = 32'd4107542400;  // 2100-03-01
    dir_secs[21] = 32'd4133980799;  // last second of 2100
    for (int i = 5; i < DIR_ROWS; i++) begin
      dir_typed[i] = 1'b0;
      dir_want[i]  = '0;
    end
  end

  // Sender: directed table, then random requests in bursts with gaps
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    mismatches = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_req(dir_secs[i], dir_typed[i], dir_want[i]);

    burst_left = $urandom_range(1, 10);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst_left == 0) begin
        // short gaps mostly, now and then a long one
        gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(20, 300);
        in_tvalid <= 1'b0;
        in_tdata  <= $urandom;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 10);
      end
      send_req(pick_secs(), 1'b0, '0);
      burst_left--;
    end
    in_tvalid <= 1'b0;

    wait (pending_dates.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("tb_epoch_to_calendar_unit OK");
    end else begin
      $display("tb_epoch_to_calendar_unit NOT OK");
    end
    $finish;
  end

  // Receiver: open, choppy or slow, switching mode at random during the run
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold;
    bit          rdy;
    mode       = RX_OPEN;
    mode_left  = 0;
    hold       = 0;
    rdy        = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(200, 1500);
      end else begin
        mode_left--;
      end
      if (hold > 0) begin
        hold--;
      end else begin
        case (mode)
          RX_OPEN: rdy = 1'b1;
          RX_CHOPPY: begin
            rdy  = !rdy;
            hold = $urandom_range(0, 3);
          end
          default: begin
            rdy  = !rdy;
            hold = rdy ? $urandom_range(0, 4) : $urandom_range(20, 250);
          end
        endcase
      end
      out_tready <= rdy;
    end
  end

  // Result check against the oldest pending date
  always @(posedge clk) begin
    cal_t got;
    cal_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = cal_t'(out_tdata[36:0]);
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("mismatch: result %h with nothing pending", out_tdata);
      end else begin
        want = pending_dates.pop_front();
        check_field("second_of_minute", 32'(want.sec), 32'(got.sec));
        check_field("minute_of_hour", 32'(want.minute), 32'(got.minute));
        check_field("hour_of_day", 32'(want.hour), 32'(got.hour));
        check_field("weekday", 32'(want.wday), 32'(got.wday));
        check_field("year_offset", 32'(want.year), 32'(got.year));
        check_field("month_number", 32'(want.month), 32'(got.month));
        check_field("day_of_month", 32'(want.mday), 32'(got.mday));
        check_field("pad bits", 0, 32'(out_tdata[39:37]));
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_epoch_to_calendar_unit NOT OK");
    $finish;
  end

endmodule
